FILE: src/cog_pkg.sv
`timescale 1ns / 1ps
// Package for the charset odometer generator: item types, command and status
// codes, and the character class tables. No dependencies.

package cog_pkg;

    localparam int DEFAULT_MAX_POSITIONS = 8;
    localparam int DEFAULT_SYMBOL_COUNT  = 24;

    localparam logic [1:0] CMD_ADVANCE  = 2'd0;
    localparam logic [1:0] CMD_LOAD_POS = 2'd1;
    localparam logic [1:0] CMD_LOAD_LEN = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [1:0] STATUS_NO_CLASS  = 2'd2;
    localparam logic [1:0] STATUS_REJECTED  = 2'd3;

    localparam logic [1:0] CLASS_LOWER  = 2'd0;
    localparam logic [1:0] CLASS_UPPER  = 2'd1;
    localparam logic [1:0] CLASS_DIGIT  = 2'd2;
    localparam logic [1:0] CLASS_SYMBOL = 2'd3;

    localparam logic [2:0] NO_CLASS = 3'd4;
    localparam int RESULT_CAP = 8;

    localparam logic [7:0] SYMBOL_TABLE [32] = '{
        8'h7e, 8'h2d, 8'h3d, 8'h5f, 8'h24, 8'h25, 8'h2b, 8'h2e,
        8'h3b, 8'h3a, 8'h5b, 8'h28, 8'h7b, 8'h7d, 8'h29, 8'h5d,
        8'h3f, 8'h40, 8'h21, 8'h23, 8'h60, 8'h5e, 8'h2a, 8'h2c,
        8'h26, 8'h7c, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] position;
        logic       load_empty;
        logic [1:0] load_class;
        logic [4:0] load_offset;
        logic [3:0] load_length;
    } in_item_t;

    typedef struct packed {
        logic [1:0] status;
        logic [7:0] character;
        logic [1:0] char_class;
        logic [4:0] char_offset;
        logic [3:0] cur_length;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic       valid;
        logic [1:0] cls;
        logic [4:0] offset;
    } digit_t;

    typedef struct packed {
        logic       empty;
        logic [1:0] cls;
        logic [4:0] offset;
    } load_t;

    typedef struct packed {
        logic load;
        logic commit;
        logic abort;
    } cell_ctrl_t;

    function automatic logic [4:0] class_size(input logic [1:0] cls,
                                              input logic [4:0] sym_count);
        logic [4:0] size;
        case (cls)
            CLASS_LOWER:  size = 5'd26;
            CLASS_UPPER:  size = 5'd26;
            CLASS_DIGIT:  size = 5'd10;
            default:      size = sym_count;
        endcase
        return size;
    endfunction

    function automatic logic [7:0] char_of(input logic [1:0] cls,
                                           input logic [4:0] off,
                                           input logic [4:0] sym_count);
        logic [7:0] ch;
        ch = 8'd0;
        case (cls)
            CLASS_LOWER:  if (off < 5'd26) ch = 8'h61 + {3'd0, off};
            CLASS_UPPER:  if (off < 5'd26) ch = 8'h41 + {3'd0, off};
            CLASS_DIGIT:  if (off < 5'd10) ch = 8'h30 + {3'd0, off};
            default:      if (off < sym_count) ch = SYMBOL_TABLE[off];
        endcase
        return ch;
    endfunction

    function automatic logic [2:0] next_class(input logic [3:0] enable,
                                              input logic [1:0] cls);
        logic [2:0] found;
        found = NO_CLASS;
        for (int k = 3; k >= 0; k--) begin
            if (k > int'(cls) && enable[k]) begin
                found = 3'(k);
            end
        end
        return found;
    endfunction

    function automatic logic [1:0] lowest_class(input logic [3:0] enable);
        logic [2:0] nc;
        nc = next_class(enable, CLASS_LOWER);
        return enable[0] ? CLASS_LOWER : nc[1:0];
    endfunction

endpackage

FILE: src/charset_odometer_generator.sv
`timescale 1ns / 1ps
// Top level of the charset odometer generator: command decode, carry and
// emission sequencer, and the row of cog_cell positions. Depends on cog_pkg.
//
// Channel   Signals                        Direction  Handshake
// command   start, busy, item              in         start && !busy
// config    cfg_valid, cfg_ready, cfg_data in         cfg_valid && cfg_ready
// result    result_valid, result           out        strobe, one cycle
//
// A load or status item has its result registered; it appears the next cycle.
// An advance walks the carry token one cell per cycle up to the stopping
// position p, then n = min(length, 8) characters follow, one per cycle; if
// every position wraps, the advance ends with an exhausted result instead.
// Reset clears every position to empty, the length, the exhausted flag and
// the class enables. Results cannot be held off by the receiver.

module charset_odometer_generator
    import cog_pkg::*;
#(
    parameter int MAX_POSITIONS = DEFAULT_MAX_POSITIONS,
    parameter int SYMBOL_COUNT  = DEFAULT_SYMBOL_COUNT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  in_item_t   item,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [3:0] cfg_data,
    output logic       result_valid,
    output out_item_t  result
);

    localparam int PW = (MAX_POSITIONS > 1) ? $clog2(MAX_POSITIONS) : 1;
    localparam int LW = $clog2(MAX_POSITIONS + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CARRY,
        ST_EMIT
    } state_t;

    state_t         state_reg, state_next;
    logic [3:0]     class_enable_reg, class_enable_next;
    logic [LW-1:0]  length_reg, length_next;
    logic           exhausted_reg, exhausted_next;
    logic [PW-1:0]  pos_cnt_reg, pos_cnt_next;
    logic [PW-1:0]  idx_reg, idx_next;
    logic [2:0]     left_reg, left_next;
    out_item_t      result_reg, result_next;
    logic           result_valid_reg, result_valid_next;

    logic           accept;
    logic           launch;
    logic           load_go;
    logic           bad_pos;
    logic           any_stop;
    logic           exhaust;
    logic [1:0]     lowest;
    logic [LW-1:0]  p1;
    digit_t         rd;
    load_t          load_data;
    logic           commit;
    logic           abort;

    logic              tok_chain [MAX_POSITIONS+1];
    logic [MAX_POSITIONS-1:0] stop_vec;
    digit_t            cell_digit [MAX_POSITIONS];
    cell_ctrl_t        cell_ctrl [MAX_POSITIONS];

    function automatic logic [3:0] len_sat(input logic [LW-1:0] len);
        logic [31:0] wide;
        wide = 32'(len);
        return (wide > 32'd15) ? 4'd15 : wide[3:0];
    endfunction

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;
    assign lowest    = lowest_class(class_enable_reg);
    assign launch    = accept && (item.cmd == CMD_ADVANCE) &&
                       (class_enable_reg != 4'd0) && !exhausted_reg;
    assign bad_pos   = (32'(item.position) >= MAX_POSITIONS) ||
                       (!item.load_empty &&
                        item.load_offset >= class_size(item.load_class,
                                                       5'(SYMBOL_COUNT)));
    assign load_go   = accept && (item.cmd == CMD_LOAD_POS) && !bad_pos;
    assign any_stop  = |stop_vec;
    assign exhaust   = tok_chain[MAX_POSITIONS];
    assign commit    = (state_reg == ST_CARRY) && any_stop;
    assign abort     = (state_reg == ST_CARRY) && exhaust;
    assign p1        = LW'(pos_cnt_reg) + LW'(1);
    assign rd        = cell_digit[idx_reg];

    assign load_data.empty  = item.load_empty;
    assign load_data.cls    = item.load_class;
    assign load_data.offset = item.load_offset;

    assign tok_chain[0] = launch;

    always_comb
    begin
        for (int i = 0; i < MAX_POSITIONS; i++) begin
            cell_ctrl[i].load   = load_go && (32'(item.position) == i);
            cell_ctrl[i].commit = commit;
            cell_ctrl[i].abort  = abort;
        end
    end

    for (genvar g = 0; g < MAX_POSITIONS; g++) begin : g_cell
        cog_cell #(
            .SYMBOL_COUNT(SYMBOL_COUNT)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .class_enable(class_enable_reg),
            .lowest      (lowest),
            .ctrl        (cell_ctrl[g]),
            .load_data   (load_data),
            .tok_in      (tok_chain[g]),
            .tok_out     (tok_chain[g+1]),
            .stop        (stop_vec[g]),
            .digit       (cell_digit[g])
        );
    end

    always_comb
    begin
        state_next        = state_reg;
        class_enable_next = class_enable_reg;
        length_next       = length_reg;
        exhausted_next    = exhausted_reg;
        pos_cnt_next      = pos_cnt_reg;
        idx_next          = idx_reg;
        left_next         = left_reg;
        result_next       = result_reg;
        result_valid_next = 1'b0;

        if (cfg_valid && cfg_ready) begin
            class_enable_next = cfg_data;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (accept) begin
                    result_valid_next       = 1'b1;
                    result_next.status      = STATUS_OK;
                    result_next.character   = 8'd0;
                    result_next.char_class  = CLASS_LOWER;
                    result_next.char_offset = 5'd0;
                    result_next.cur_length  = len_sat(length_reg);
                    result_next.last        = 1'b1;
                    case (item.cmd)
                        CMD_ADVANCE:
                        begin
                            if (class_enable_reg == 4'd0) begin
                                result_next.status = STATUS_NO_CLASS;
                            end else if (exhausted_reg) begin
                                result_next.status = STATUS_EXHAUSTED;
                            end else begin
                                result_valid_next = 1'b0;
                                pos_cnt_next      = '0;
                                state_next        = ST_CARRY;
                            end
                        end
                        CMD_LOAD_POS:
                        begin
                            if (bad_pos) begin
                                result_next.status = STATUS_REJECTED;
                            end
                        end
                        CMD_LOAD_LEN:
                        begin
                            if (32'(item.load_length) > MAX_POSITIONS) begin
                                result_next.status = STATUS_REJECTED;
                            end else begin
                                length_next            = LW'(item.load_length);
                                result_next.cur_length = len_sat(LW'(item.load_length));
                            end
                        end
                        default:
                        begin
                            result_next.status = STATUS_REJECTED;
                        end
                    endcase
                end
            end
            ST_CARRY:
            begin
                if (any_stop) begin
                    if (p1 > length_reg) begin
                        length_next = p1;
                    end
                    idx_next   = PW'(length_next - LW'(1));
                    left_next  = (32'(length_next) > RESULT_CAP) ?
                                 3'(RESULT_CAP - 1) : 3'(32'(length_next) - 32'd1);
                    state_next = ST_EMIT;
                end else if (exhaust) begin
                    exhausted_next          = 1'b1;
                    result_valid_next       = 1'b1;
                    result_next.status      = STATUS_EXHAUSTED;
                    result_next.character   = 8'd0;
                    result_next.char_class  = CLASS_LOWER;
                    result_next.char_offset = 5'd0;
                    result_next.cur_length  = len_sat(length_reg);
                    result_next.last        = 1'b1;
                    state_next              = ST_IDLE;
                end else begin
                    pos_cnt_next = pos_cnt_reg + PW'(1);
                end
            end
            ST_EMIT:
            begin
                result_valid_next       = 1'b1;
                result_next.status      = STATUS_OK;
                result_next.character   = rd.valid ?
                                          char_of(rd.cls, rd.offset, 5'(SYMBOL_COUNT)) : 8'd0;
                result_next.char_class  = rd.valid ? rd.cls : CLASS_LOWER;
                result_next.char_offset = rd.valid ? rd.offset : 5'd0;
                result_next.cur_length  = len_sat(length_reg);
                result_next.last        = (left_reg == 3'd0);
                idx_next                = idx_reg - PW'(1);
                left_next               = left_reg - 3'd1;
                if (left_reg == 3'd0) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg        <= ST_IDLE;
            class_enable_reg <= 4'd0;
            length_reg       <= '0;
            exhausted_reg    <= 1'b0;
            pos_cnt_reg      <= '0;
            idx_reg          <= '0;
            left_reg         <= 3'd0;
            result_reg       <= '0;
            result_valid_reg <= 1'b0;
        end else begin
            state_reg        <= state_next;
            class_enable_reg <= class_enable_next;
            length_reg       <= length_next;
            exhausted_reg    <= exhausted_next;
            pos_cnt_reg      <= pos_cnt_next;
            idx_reg          <= idx_next;
            left_reg         <= left_next;
            result_reg       <= result_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // The carry token only lives while the sequencer walks it.
    a_token_in_carry: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_CARRY) |-> (!any_stop && !exhaust))
        else $error("carry token outside carry walk");

    a_single_stop: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(stop_vec))
        else $error("more than one position stopped the carry");

    a_length_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(length_reg) <= MAX_POSITIONS)
        else $error("length beyond the number of positions");

    a_exhausted_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        exhausted_reg |=> exhausted_reg)
        else $error("exhausted flag cleared without reset");

endmodule

FILE: src/cog_cell.sv
`timescale 1ns / 1ps
// One odometer position: holds its class and offset and passes the carry
// token to the next position. Depends on cog_pkg.

module cog_cell
    import cog_pkg::*;
#(
    parameter int SYMBOL_COUNT = DEFAULT_SYMBOL_COUNT
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [3:0] class_enable,
    input  logic [1:0] lowest,
    input  cell_ctrl_t ctrl,
    input  load_t      load_data,
    input  logic       tok_in,
    output logic       tok_out,
    output logic       stop,
    output digit_t     digit
);

    digit_t     digit_reg, digit_next;
    logic       tok_reg;
    logic       passed_reg, passed_next;
    logic [4:0] size;
    logic [2:0] nc;
    logic       step_in;
    logic       wrap;

    always_comb
    begin
        size    = class_size(digit_reg.cls, 5'(SYMBOL_COUNT));
        nc      = next_class(class_enable, digit_reg.cls);
        step_in = class_enable[digit_reg.cls] &&
                  (({1'b0, digit_reg.offset} + 6'd1) < {1'b0, size});
        wrap    = digit_reg.valid && !step_in && (nc == NO_CLASS);
        tok_out = tok_reg && wrap;
        stop    = tok_reg && !wrap;
    end

    always_comb
    begin
        digit_next  = digit_reg;
        passed_next = passed_reg;
        if (ctrl.load) begin
            digit_next.valid  = !load_data.empty;
            digit_next.cls    = load_data.empty ? CLASS_LOWER : load_data.cls;
            digit_next.offset = load_data.empty ? 5'd0 : load_data.offset;
        end else if (stop) begin
            if (!digit_reg.valid) begin
                digit_next.valid  = 1'b1;
                digit_next.cls    = lowest;
                digit_next.offset = 5'd0;
            end else if (step_in) begin
                digit_next.offset = digit_reg.offset + 5'd1;
            end else begin
                digit_next.cls    = nc[1:0];
                digit_next.offset = 5'd0;
            end
        end else if (ctrl.commit && passed_reg) begin
            digit_next.cls    = lowest;
            digit_next.offset = 5'd0;
        end
        if (tok_out) begin
            passed_next = 1'b1;
        end else if (ctrl.commit || ctrl.abort) begin
            passed_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            digit_reg  <= '0;
            tok_reg    <= 1'b0;
            passed_reg <= 1'b0;
        end else begin
            digit_reg  <= digit_next;
            tok_reg    <= tok_in;
            passed_reg <= passed_next;
        end
    end

    assign digit = digit_reg;

endmodule
